FILE: rtl/core/irqoc_pkg.sv
// ----------------------------------------------------------------------------
// irqoc_pkg: shared types and constants for the interval ring queue
// Holds the entry layout, operation and status codes, and the limits used to
// validate packed time stamps.
// ----------------------------------------------------------------------------
package irqoc_pkg;

  // Default number of ring slots
  localparam int unsigned DEF_QUEUE_DEPTH = 128;

  // Field widths of the item payload
  localparam int unsigned TIME_W = 32;
  localparam int unsigned PRI_W  = 8;
  localparam int unsigned SLOT_W = 7;
  localparam int unsigned LIVE_W = 8;

  // Packed time field limits
  localparam logic [11:0] YEAR_MIN  = 12'd1900;
  localparam logic [3:0]  MONTH_MAX = 4'd12;
  localparam logic [4:0]  DAY_MAX   = 5'd31;
  localparam logic [4:0]  HOUR_MAX  = 5'd23;
  localparam logic [5:0]  MIN_MAX   = 6'd59;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_DEL   = 2'd2,
    MODE_QUERY = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_OVERLAP = 3'd2,
    ST_INVALID = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_BADSLOT = 3'd5
  } status_t;

  // One stored interval
  typedef struct packed {
    logic [PRI_W-1:0]  pri;
    logic [TIME_W-1:0] end_t;
    logic [TIME_W-1:0] start_t;
  } entry_t;

  // Memory port strobes
  typedef struct packed {
    logic we;
    logic re;
  } mem_cmd_t;

  // Compare unit results
  typedef struct packed {
    logic time_valid;
    logic overlap;
  } cmp_res_t;

endpackage

FILE: rtl/core/irqoc_mem.sv
// ----------------------------------------------------------------------------
// irqoc_mem: entry store
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module irqoc_mem #(
  parameter int unsigned DEPTH = irqoc_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned AW    = 7
) (
  input  logic                clk,
  input  irqoc_pkg::mem_cmd_t cmd,
  input  logic [AW-1:0]       waddr,
  input  irqoc_pkg::entry_t   wdata,
  input  logic [AW-1:0]       raddr,
  output irqoc_pkg::entry_t   rdata
);
  import irqoc_pkg::*;

  entry_t mem_q [DEPTH];

  // Write entry
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem_q[waddr] <= wdata;
    end
  end

  // Read entry, registered
  always_ff @(posedge clk) begin
    if (cmd.re) begin
      rdata <= mem_q[raddr];
    end
  end

endmodule

FILE: rtl/core/irqoc_cmp.sv
// ----------------------------------------------------------------------------
// irqoc_cmp: interval compare unit
// Validates the request interval and tests it for a closed-bound overlap
// against the entry just read from the store.
// ----------------------------------------------------------------------------
module irqoc_cmp (
  input  logic [irqoc_pkg::TIME_W-1:0] req_start,
  input  logic [irqoc_pkg::TIME_W-1:0] req_end,
  input  irqoc_pkg::entry_t            entry,
  output irqoc_pkg::cmp_res_t          res
);
  import irqoc_pkg::*;

  function automatic logic time_ok(input logic [TIME_W-1:0] t);
    logic ok;
    ok = 1'b1;
    if (t[10:6] > HOUR_MAX) ok = 1'b0;
    if (t[5:0] > MIN_MAX) ok = 1'b0;
    if (t[15:11] == 5'd0 || t[15:11] > DAY_MAX) ok = 1'b0;
    if (t[19:16] == 4'd0 || t[19:16] > MONTH_MAX) ok = 1'b0;
    if (t[31:20] < YEAR_MIN) ok = 1'b0;
    return ok;
  endfunction

  logic start_in, end_in, covers;

  // Check request interval
  assign res.time_valid = time_ok(req_start) && time_ok(req_end) && (req_end > req_start);

  // Test closed-interval overlap with the stored entry
  assign start_in = (req_start >= entry.start_t) && (req_start <= entry.end_t);
  assign end_in   = (req_end >= entry.start_t) && (req_end <= entry.end_t);
  assign covers   = (req_start <= entry.start_t) && (req_end >= entry.end_t);
  assign res.overlap = start_in || end_in || covers;

endmodule

FILE: rtl/core/irqoc_ctrl.sv
// ----------------------------------------------------------------------------
// irqoc_ctrl: queue sequencer
// Latches one item, runs the scan, pop or shifting delete against the entry
// store and hands the result to a registered output stage.
// ----------------------------------------------------------------------------
module irqoc_ctrl #(
  parameter int unsigned QUEUE_DEPTH = irqoc_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request side
  input  logic                          req_valid,
  output logic                          req_ready,
  input  irqoc_pkg::mode_t              req_mode,
  input  logic [irqoc_pkg::TIME_W-1:0]  req_start,
  input  logic [irqoc_pkg::TIME_W-1:0]  req_end,
  input  logic [irqoc_pkg::PRI_W-1:0]   req_pri,
  input  logic [irqoc_pkg::SLOT_W-1:0]  req_slot,
  input  logic                          req_skip,
  // result side
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output irqoc_pkg::status_t            rsp_status,
  output logic [irqoc_pkg::SLOT_W-1:0]  rsp_hit,
  output logic [irqoc_pkg::TIME_W-1:0]  rsp_start,
  output logic [irqoc_pkg::TIME_W-1:0]  rsp_end,
  output logic [irqoc_pkg::PRI_W-1:0]   rsp_pri,
  output logic [irqoc_pkg::LIVE_W-1:0]  rsp_live,
  // compare unit
  output logic [irqoc_pkg::TIME_W-1:0]  cmp_start,
  output logic [irqoc_pkg::TIME_W-1:0]  cmp_end,
  input  irqoc_pkg::cmp_res_t           cmp_res,
  // entry store
  output irqoc_pkg::mem_cmd_t           mem_cmd,
  output logic [AW-1:0]                 mem_waddr,
  output irqoc_pkg::entry_t             mem_wdata,
  output logic [AW-1:0]                 mem_raddr,
  input  irqoc_pkg::entry_t             mem_rdata
);
  import irqoc_pkg::*;

  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SLW = (AW + 1 > SLOT_W) ? AW + 1 : SLOT_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SCAN, S_POP, S_SHIFT, S_FIN
  } state_t;

  function automatic logic [AW-1:0] inc_slot(input logic [AW-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + AW'(1);
  endfunction

  function automatic logic [AW-1:0] dec_slot(input logic [AW-1:0] s);
    return (s == '0) ? LAST_SLOT : s - AW'(1);
  endfunction

  state_t state_r;

  // latched item
  mode_t               mode_r;
  logic [TIME_W-1:0]   ns_r, ne_r;
  logic [PRI_W-1:0]    pri_r;
  logic [SLOT_W-1:0]   slot_r;
  logic                skip_r;

  // queue pointers
  logic [AW-1:0]       head_r, tail_r;
  logic [CW-1:0]       count_r;

  // scan and shift walkers
  logic [AW-1:0]       iss_slot_r;
  logic [CW-1:0]       iss_k_r;
  logic                dv_r;
  logic [AW-1:0]       chk_slot_r;
  logic                chk_last_r;
  logic [AW-1:0]       sh_dst_r;
  logic [CW-1:0]       sh_left_r;

  // pending result
  status_t             res_status_r;
  logic [SLOT_W-1:0]   res_hit_r;
  logic [TIME_W-1:0]   res_start_r, res_end_r;
  logic [PRI_W-1:0]    res_pri_r;

  // output stage
  logic                out_valid_r;
  status_t             out_status_r;
  logic [SLOT_W-1:0]   out_hit_r;
  logic [TIME_W-1:0]   out_start_r, out_end_r;
  logic [PRI_W-1:0]    out_pri_r;
  logic [LIVE_W-1:0]   out_live_r;

  // delete decode
  logic [SLW-1:0] slot_w, head_w, off_w, moves_w;
  logic           slot_bad, off_bad;
  logic [AW-1:0]  slot_a, del_n1;

  // scan decode
  logic scan_issue, skip_hit, scan_hit, scan_done;
  logic out_free;

  assign slot_w   = SLW'(slot_r);
  assign head_w   = SLW'(head_r);
  assign slot_bad = slot_w >= SLW'(QUEUE_DEPTH);
  assign off_w    = (slot_w >= head_w) ? slot_w - head_w
                                       : slot_w + SLW'(QUEUE_DEPTH) - head_w;
  assign off_bad  = off_w >= SLW'(count_r);
  assign moves_w  = SLW'(count_r) - off_w - SLW'(1);
  assign slot_a   = AW'(slot_r);
  assign del_n1   = inc_slot(slot_a);

  assign scan_issue = iss_k_r < count_r;
  assign skip_hit   = (mode_r == MODE_QUERY) && skip_r &&
                      (SLW'(slot_r) == SLW'(chk_slot_r));
  assign scan_hit   = dv_r && cmp_res.overlap && !skip_hit;
  assign scan_done  = dv_r && !scan_hit && chk_last_r;
  assign out_free   = !out_valid_r || rsp_ready;

  assign req_ready  = (state_r == S_IDLE);
  assign cmp_start  = ns_r;
  assign cmp_end    = ne_r;

  assign rsp_valid  = out_valid_r;
  assign rsp_status = out_status_r;
  assign rsp_hit    = out_hit_r;
  assign rsp_start  = out_start_r;
  assign rsp_end    = out_end_r;
  assign rsp_pri    = out_pri_r;
  assign rsp_live   = out_live_r;

  // Drive entry store ports
  always_comb begin
    mem_cmd         = '0;
    mem_waddr       = tail_r;
    mem_raddr       = iss_slot_r;
    mem_wdata.pri   = pri_r;
    mem_wdata.end_t = ne_r;
    mem_wdata.start_t = ns_r;
    unique case (state_r)
      S_EXEC: begin
        unique case (mode_r)
          MODE_PUSH: begin
            mem_cmd.we = cmp_res.time_valid && (count_r == '0);
          end
          MODE_POP: begin
            mem_cmd.re = (count_r != '0);
            mem_raddr  = head_r;
          end
          MODE_DEL: begin
            mem_cmd.re = (count_r != '0) && !slot_bad && !off_bad && (moves_w != '0);
            mem_raddr  = del_n1;
          end
          MODE_QUERY: begin
            mem_cmd = '0;
          end
          default: mem_cmd = '0;
        endcase
      end
      S_SCAN: begin
        mem_cmd.re = scan_issue;
        mem_cmd.we = scan_done && (mode_r == MODE_PUSH);
      end
      S_SHIFT: begin
        mem_cmd.we = 1'b1;
        mem_waddr  = sh_dst_r;
        mem_wdata  = mem_rdata;
        mem_cmd.re = (sh_left_r != '0);
      end
      default: mem_cmd = '0;
    endcase
  end

  // Sequence one item and hold the output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the result once taken; the finish step reloads it itself
      if (rsp_ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (req_valid) begin
            mode_r  <= req_mode;
            ns_r    <= req_start;
            ne_r    <= req_end;
            pri_r   <= req_pri;
            slot_r  <= req_slot;
            skip_r  <= req_skip;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_hit_r    <= '0;
          res_start_r  <= '0;
          res_end_r    <= '0;
          res_pri_r    <= '0;
          dv_r         <= 1'b0;
          iss_k_r      <= '0;
          unique case (mode_r)
            MODE_PUSH: begin
              iss_slot_r <= head_r;
              priority if (!cmp_res.time_valid) begin
                res_status_r <= ST_INVALID;
                state_r      <= S_FIN;
              end else if (count_r >= CW'(QUEUE_DEPTH)) begin
                res_status_r <= ST_FULL;
                state_r      <= S_FIN;
              end else if (count_r == '0) begin
                res_status_r <= ST_OK;
                tail_r       <= inc_slot(tail_r);
                count_r      <= count_r + CW'(1);
                state_r      <= S_FIN;
              end else begin
                res_status_r <= ST_OK;
                state_r      <= S_SCAN;
              end
            end
            MODE_POP: begin
              if (count_r == '0) begin
                res_status_r <= ST_EMPTY;
                state_r      <= S_FIN;
              end else begin
                res_status_r <= ST_OK;
                state_r      <= S_POP;
              end
            end
            MODE_DEL: begin
              iss_slot_r <= inc_slot(del_n1);
              priority if (count_r == '0) begin
                res_status_r <= ST_EMPTY;
                state_r      <= S_FIN;
              end else if (slot_bad || off_bad) begin
                res_status_r <= ST_BADSLOT;
                state_r      <= S_FIN;
              end else if (moves_w == '0) begin
                res_status_r <= ST_OK;
                if (count_r == CW'(1)) begin
                  head_r <= '0;
                  tail_r <= '0;
                end else begin
                  tail_r <= dec_slot(tail_r);
                end
                count_r <= count_r - CW'(1);
                state_r <= S_FIN;
              end else begin
                res_status_r <= ST_OK;
                sh_dst_r     <= slot_a;
                sh_left_r    <= CW'(moves_w - SLW'(1));
                state_r      <= S_SHIFT;
              end
            end
            MODE_QUERY: begin
              iss_slot_r   <= head_r;
              res_status_r <= ST_OK;
              if (count_r != '0) begin
                state_r <= S_SCAN;
              end else begin
                state_r <= S_FIN;
              end
            end
            default: begin
              res_status_r <= ST_OK;
              state_r      <= S_FIN;
            end
          endcase
        end
        S_SCAN: begin
          // issue side: one read per cycle from head onward
          dv_r <= scan_issue;
          if (scan_issue) begin
            iss_slot_r <= inc_slot(iss_slot_r);
            iss_k_r    <= iss_k_r + CW'(1);
            chk_slot_r <= iss_slot_r;
            chk_last_r <= (CW'(iss_k_r + CW'(1)) == count_r);
          end
          // check side: data from the read issued in the previous cycle
          if (scan_hit) begin
            res_status_r <= ST_OVERLAP;
            res_hit_r    <= SLOT_W'(chk_slot_r);
            state_r      <= S_FIN;
          end else if (scan_done) begin
            if (mode_r == MODE_PUSH) begin
              tail_r  <= inc_slot(tail_r);
              count_r <= count_r + CW'(1);
            end
            state_r <= S_FIN;
          end
        end
        S_POP: begin
          res_start_r <= mem_rdata.start_t;
          res_end_r   <= mem_rdata.end_t;
          res_pri_r   <= mem_rdata.pri;
          count_r     <= count_r - CW'(1);
          if (count_r == CW'(1)) begin
            head_r <= '0;
            tail_r <= '0;
          end else begin
            head_r <= inc_slot(head_r);
          end
          state_r <= S_FIN;
        end
        S_SHIFT: begin
          // move the entry read last cycle down one place
          if (sh_left_r != '0) begin
            sh_dst_r   <= inc_slot(sh_dst_r);
            iss_slot_r <= inc_slot(iss_slot_r);
            sh_left_r  <= sh_left_r - CW'(1);
          end else begin
            if (count_r == CW'(1)) begin
              head_r <= '0;
              tail_r <= '0;
            end else begin
              tail_r <= dec_slot(tail_r);
            end
            count_r <= count_r - CW'(1);
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_hit_r    <= res_hit_r;
            out_start_r  <= res_start_r;
            out_end_r    <= res_end_r;
            out_pri_r    <= res_pri_r;
            out_live_r   <= LIVE_W'(count_r);
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Occupancy never exceeds the ring
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  // An empty ring parks both pointers at slot zero
  a_empty_park: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == '0 && tail_r == '0))
    else $error("empty queue with pointers away from zero");

  // The shift never reads and writes the same entry in one cycle
  a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_cmd.we && mem_cmd.re) |-> (mem_waddr != mem_raddr))
    else $error("read and write collide on one entry");

  // From the finish step, a free output stage takes the result and the sequencer goes idle
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished result not loaded");

endmodule

FILE: rtl/core/interval_ring_queue_with_overlap_check.sv
// ----------------------------------------------------------------------------
// interval_ring_queue_with_overlap_check: ring queue of time intervals
// Push with validation and overlap scan, pop, shifting delete and overlap
// query over a memory-backed ring of entries.
//
//  channel | dir | tdata (low bit up)                                | tuser
//  in_     | in  | start_time, end_time, priority_req, slot, skip_valid | mode
//  out_    | out | hit_slot, out_start, out_end, out_priority,          | status
//          |     | live_count, one zero pad bit                          |
//
// Pop runs the execute, pop and finish steps; the finish step loads the output
// register once it is free. Push and query scan the live entries one store read
// per cycle; a shifting delete moves each entry after the slot down one place.
// Errors, a push into an empty ring and a delete of the last entry go from the
// execute step straight to the finish step. The next item can be accepted once
// the result is loaded. One item is in work at a time; a new item is taken while
// the previous result still waits in the output register. Reset clears pointers
// and count; the store itself needs no clearing.
// ----------------------------------------------------------------------------
module interval_ring_queue_with_overlap_check #(
  parameter int unsigned QUEUE_DEPTH = irqoc_pkg::DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // start_time[31:0] end_time[63:32] priority_req[71:64] slot[78:72] skip_valid[79]
  input  logic [79:0] in_tdata,
  // mode[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // hit_slot[6:0] out_start[38:7] out_end[70:39] out_priority[78:71]
  // live_count[86:79] zero[87]
  output logic [87:0] out_tdata,
  // status[2:0]
  output logic [2:0]  out_tuser
);
  import irqoc_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  mem_cmd_t          mem_cmd;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  entry_t            mem_wdata, mem_rdata;
  logic [TIME_W-1:0] cmp_start, cmp_end;
  cmp_res_t          cmp_res;
  status_t           rsp_status;
  logic [SLOT_W-1:0] rsp_hit;
  logic [TIME_W-1:0] rsp_start, rsp_end;
  logic [PRI_W-1:0]  rsp_pri;
  logic [LIVE_W-1:0] rsp_live;

  irqoc_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req_mode   (mode_t'(in_tuser)),
    .req_start  (in_tdata[31:0]),
    .req_end    (in_tdata[63:32]),
    .req_pri    (in_tdata[71:64]),
    .req_slot   (in_tdata[78:72]),
    .req_skip   (in_tdata[79]),
    .rsp_valid  (out_tvalid),
    .rsp_ready  (out_tready),
    .rsp_status (rsp_status),
    .rsp_hit    (rsp_hit),
    .rsp_start  (rsp_start),
    .rsp_end    (rsp_end),
    .rsp_pri    (rsp_pri),
    .rsp_live   (rsp_live),
    .cmp_start  (cmp_start),
    .cmp_end    (cmp_end),
    .cmp_res    (cmp_res),
    .mem_cmd    (mem_cmd),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  irqoc_cmp u_cmp (
    .req_start (cmp_start),
    .req_end   (cmp_end),
    .entry     (mem_rdata),
    .res       (cmp_res)
  );

  irqoc_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .cmd   (mem_cmd),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Pack result item
  assign out_tdata = {1'b0, rsp_live, rsp_pri, rsp_end, rsp_start, rsp_hit};
  assign out_tuser = rsp_status;

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the interval ring queue
// Drives a short directed plan through the corner cases (empty queue, each
// invalid time field, touching bounds, bad delete slots), then a random run
// that fills, drains and churns the ring. A shadow copy of the queue predicts
// every result, and a monitor compares each result field by field.
// ----------------------------------------------------------------------------
module testbench;
  import irqoc_pkg::*;

  localparam int DEPTH        = DEF_QUEUE_DEPTH;
  localparam int RAND_ITEMS   = 1000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int PRINT_CAP    = 40;

  typedef struct packed {
    status_t     status;
    logic [6:0]  hit;
    logic [31:0] o_start;
    logic [31:0] o_end;
    logic [7:0]  o_pri;
    logic [7:0]  live;
  } verdict_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] s;
    logic [31:0] e;
    logic [7:0]  pri;
    logic [6:0]  slot;
    logic        skip;
    logic        typed;
    verdict_t    want;
  } plan_row_t;

  typedef enum {GROW, SHRINK, MIXED} drift_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;
  logic [2:0]  out_tuser;

  // Shadow copy of the ring
  logic [31:0] shadow_start [DEPTH];
  logic [31:0] shadow_end [DEPTH];
  logic [7:0]  shadow_pri [DEPTH];
  int          shadow_head;
  int          shadow_tail;
  int          shadow_count;

  verdict_t    pending_verdicts[$];
  plan_row_t   plan[$];

  int mismatch_count;
  int cycle_count;
  int mode_seen [4];
  int status_seen [6];
  int peak_count;
  bit calm;
  bit stall_request;

  interval_ring_queue_with_overlap_check #(
    .QUEUE_DEPTH(DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] pack_stamp(int y, int mo, int d, int h, int mi);
    logic [11:0] yy;
    logic [3:0]  mm;
    logic [4:0]  dd;
    logic [4:0]  hh;
    logic [5:0]  mn;
    yy = y;
    mm = mo;
    dd = d;
    hh = h;
    mn = mi;
    return {yy, mm, dd, hh, mn};
  endfunction

  function automatic bit stamp_valid(logic [31:0] t);
    return (t[10:6] <= HOUR_MAX) && (t[5:0] <= MIN_MAX) &&
           (t[15:11] >= 5'd1) && (t[15:11] <= DAY_MAX) &&
           (t[19:16] >= 4'd1) && (t[19:16] <= MONTH_MAX) &&
           (t[31:20] >= YEAR_MIN);
  endfunction

  function automatic int live_slot(int k);
    return (shadow_head + k) % DEPTH;
  endfunction

  // Walk live entries from the head; report the first closed-bound overlap
  function automatic bit scan_overlap(logic [31:0] ns, logic [31:0] ne, bit skip,
                                      int skip_slot, output int hit);
    int s;
    hit = 0;
    for (int k = 0; k < shadow_count; k++) begin
      s = live_slot(k);
      if (!(skip && s == skip_slot)) begin
        if ((ns >= shadow_start[s] && ns <= shadow_end[s]) ||
            (ne >= shadow_start[s] && ne <= shadow_end[s]) ||
            (ns <= shadow_start[s] && ne >= shadow_end[s])) begin
          hit = s;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // Apply one item to the shadow ring and return the result it should produce
  function automatic verdict_t predict_verdict(mode_t m, logic [31:0] ns, logic [31:0] ne,
                                               logic [7:0] pri, logic [6:0] slot, bit skip);
    verdict_t r;
    int hit;
    int off;
    int s;
    int n;
    r = '0;
    r.status = ST_OK;
    hit = 0;
    case (m)
      MODE_PUSH: begin
        if (!stamp_valid(ns) || !stamp_valid(ne) || ne <= ns) begin
          r.status = ST_INVALID;
        end else if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (scan_overlap(ns, ne, 1'b0, 0, hit)) begin
          r.status = ST_OVERLAP;
        end else begin
          shadow_start[shadow_tail] = ns;
          shadow_end[shadow_tail]   = ne;
          shadow_pri[shadow_tail]   = pri;
          shadow_tail  = (shadow_tail + 1) % DEPTH;
          shadow_count = shadow_count + 1;
        end
      end
      MODE_POP: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.o_start    = shadow_start[shadow_head];
          r.o_end      = shadow_end[shadow_head];
          r.o_pri      = shadow_pri[shadow_head];
          shadow_head  = (shadow_head + 1) % DEPTH;
          shadow_count = shadow_count - 1;
        end
      end
      MODE_DEL: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          off = (slot >= shadow_head) ? slot - shadow_head : slot + DEPTH - shadow_head;
          if (off >= shadow_count) begin
            r.status = ST_BADSLOT;
          end else begin
            // shift the later entries down one place
            s = slot;
            for (int k = off + 1; k < shadow_count; k++) begin
              n = (s + 1) % DEPTH;
              shadow_start[s] = shadow_start[n];
              shadow_end[s]   = shadow_end[n];
              shadow_pri[s]   = shadow_pri[n];
              s = n;
            end
            shadow_tail  = (shadow_tail + DEPTH - 1) % DEPTH;
            shadow_count = shadow_count - 1;
          end
        end
      end
      default: begin
        if (scan_overlap(ns, ne, skip, slot, hit)) r.status = ST_OVERLAP;
      end
    endcase
    // an emptied ring restarts at slot zero
    if (shadow_count == 0) begin
      shadow_head = 0;
      shadow_tail = 0;
    end
    if (r.status == ST_OVERLAP) r.hit = hit[6:0];
    r.live = shadow_count[7:0];
    return r;
  endfunction

  function automatic plan_row_t plan_row(mode_t m, logic [31:0] s, logic [31:0] e,
                                         logic [7:0] pri, logic [6:0] slot, bit skip,
                                         bit typed, status_t st, logic [6:0] hit,
                                         logic [7:0] live);
    plan_row_t r;
    r = '0;
    r.mode        = m;
    r.s           = s;
    r.e           = e;
    r.pri         = pri;
    r.slot        = slot;
    r.skip        = skip;
    r.typed       = typed;
    r.want.status = st;
    r.want.hit    = hit;
    r.want.live   = live;
    return r;
  endfunction

  // Short valid interval inside one hour, sometimes running into a later hour of the day
  function automatic void fresh_interval(output logic [31:0] s, output logic [31:0] e);
    int y;
    int mo;
    int d;
    int h;
    int m0;
    y  = $urandom_range(4095, 1900);
    mo = $urandom_range(12, 1);
    d  = $urandom_range(31, 1);
    h  = $urandom_range(23, 0);
    m0 = $urandom_range(58, 0);
    s  = pack_stamp(y, mo, d, h, m0);
    if (h < 23 && $urandom_range(3) == 0)
      e = pack_stamp(y, mo, d, $urandom_range(23, h + 1), $urandom_range(59, 0));
    else
      e = pack_stamp(y, mo, d, h, $urandom_range(59, m0 + 1));
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    // keep the log short when everything goes wrong
    if (mismatch_count < PRINT_CAP)
      $display("mismatch: %s got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  // Offer one item, wait for acceptance, then queue its expected result
  task automatic offer_item(mode_t m, logic [31:0] s, logic [31:0] e, logic [7:0] pri,
                            logic [6:0] slot, bit skip, bit typed, verdict_t want);
    verdict_t guess;
    while (!calm && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {skip, slot, pri, e, s};
    in_tuser  <= m;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    guess = predict_verdict(m, s, e, pri, slot, skip);
    pending_verdicts.push_back(typed ? want : guess);
    mode_seen[int'(m)]++;
    status_seen[int'(guess.status)]++;
    if (shadow_count > peak_count) peak_count = shadow_count;
    @(negedge clk);
  endtask

  // Drop valid and hold until every pending result has come back
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_verdicts.size() != 0);
  endtask

  // Result checker
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        flag_mismatch("result with nothing pending, status", out_tuser, 0);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_tuser !== want.status)
          flag_mismatch("status", out_tuser, want.status);
        if (out_tdata[6:0] !== want.hit)
          flag_mismatch("hit_slot", out_tdata[6:0], want.hit);
        if (out_tdata[38:7] !== want.o_start)
          flag_mismatch("out_start", out_tdata[38:7], want.o_start);
        if (out_tdata[70:39] !== want.o_end)
          flag_mismatch("out_end", out_tdata[70:39], want.o_end);
        if (out_tdata[78:71] !== want.o_pri)
          flag_mismatch("out_priority", out_tdata[78:71], want.o_pri);
        if (out_tdata[86:79] !== want.live)
          flag_mismatch("live_count", out_tdata[86:79], want.live);
        if (out_tdata[87] !== 1'b0)
          flag_mismatch("pad bit", out_tdata[87], 0);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        stall_request = 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 9);
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [31:0] a_s;
    logic [31:0] a_e;
    logic [31:0] b_s;
    logic [31:0] b_e;
    logic [31:0] c_s;
    logic [31:0] c_e;
    logic [31:0] v_s;
    logic [31:0] v_e;
    logic [31:0] a;
    logic [31:0] b;
    logic [7:0]  p;
    logic [6:0]  sl;
    bit          sk;
    mode_t       m;
    drift_t      drift;
    verdict_t    none;
    int          roll;
    int          k;
    int          pcut;
    int          ocut;
    int          dcut;
    int          qcut;

    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = MODE_PUSH;
    calm          = 1'b0;
    stall_request = 1'b0;
    mismatch_count = 0;
    peak_count    = 0;
    shadow_head   = 0;
    shadow_tail   = 0;
    shadow_count  = 0;
    none          = '0;

    a_s = pack_stamp(1900, 1, 1, 0, 0);
    a_e = pack_stamp(1900, 1, 1, 0, 59);
    b_s = pack_stamp(4095, 12, 31, 23, 0);
    b_e = pack_stamp(4095, 12, 31, 23, 59);
    c_s = pack_stamp(2000, 6, 15, 12, 0);
    c_e = pack_stamp(2000, 6, 15, 12, 30);
    v_s = pack_stamp(2024, 3, 10, 8, 0);
    v_e = pack_stamp(2024, 3, 10, 8, 30);

    // Directed plan: empty queue, each bad time field, extremes, touching bounds
    plan.push_back(plan_row(MODE_POP, 0, 0, 0, 0, 0, 1, ST_EMPTY, 0, 0));
    plan.push_back(plan_row(MODE_DEL, 0, 0, 0, 0, 0, 1, ST_EMPTY, 0, 0));
    plan.push_back(plan_row(MODE_QUERY, v_s, v_e, 0, 0, 0, 1, ST_OK, 0, 0));
    plan.push_back(plan_row(MODE_PUSH, pack_stamp(2024, 3, 10, 24, 0), v_e, 1, 0, 0,
                            1, ST_INVALID, 0, 0));
    plan.push_back(plan_row(MODE_PUSH, v_s, pack_stamp(2024, 3, 10, 8, 60), 1, 0, 0,
                            1, ST_INVALID, 0, 0));
    plan.push_back(plan_row(MODE_PUSH, pack_stamp(2024, 3, 0, 8, 0), v_e, 1, 0, 0,
                            1, ST_INVALID, 0, 0));
    plan.push_back(plan_row(MODE_PUSH, v_s, pack_stamp(2024, 13, 10, 8, 0), 1, 0, 0,
                            1, ST_INVALID, 0, 0));
    plan.push_back(plan_row(MODE_PUSH, pack_stamp(2024, 0, 10, 8, 0), v_e, 1, 0, 0,
                            1, ST_INVALID, 0, 0));
    plan.push_back(plan_row(MODE_PUSH, pack_stamp(1899, 3, 10, 8, 0), v_e, 1, 0, 0,
                            1, ST_INVALID, 0, 0));
    plan.push_back(plan_row(MODE_PUSH, v_s, v_s, 1, 0, 0, 1, ST_INVALID, 0, 0));
    plan.push_back(plan_row(MODE_PUSH, v_e, v_s, 1, 0, 0, 1, ST_INVALID, 0, 0));
    plan.push_back(plan_row(MODE_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 7'h7F, 1,
                            1, ST_INVALID, 0, 0));
    plan.push_back(plan_row(MODE_PUSH, a_s, a_e, 8'hFF, 0, 0, 1, ST_OK, 0, 1));
    plan.push_back(plan_row(MODE_PUSH, b_s, b_e, 8'h00, 0, 0, 1, ST_OK, 0, 2));
    // new start on an old end, then new end on an old start
    plan.push_back(plan_row(MODE_PUSH, a_e, pack_stamp(1900, 1, 1, 1, 0), 3, 0, 0,
                            1, ST_OVERLAP, 0, 2));
    plan.push_back(plan_row(MODE_PUSH, pack_stamp(4095, 12, 31, 22, 0), b_s, 3, 0, 0,
                            1, ST_OVERLAP, 1, 2));
    plan.push_back(plan_row(MODE_PUSH, c_s, c_e, 8'h5A, 0, 0, 1, ST_OK, 0, 3));
    plan.push_back(plan_row(MODE_QUERY, v_s, v_e, 0, 0, 0, 0, ST_OK, 0, 0));
    plan.push_back(plan_row(MODE_QUERY, 0, 32'hFFFF_FFFF, 0, 1, 1, 0, ST_OK, 0, 0));
    plan.push_back(plan_row(MODE_QUERY, c_s, c_e, 0, 2, 1, 0, ST_OK, 0, 0));
    plan.push_back(plan_row(MODE_QUERY, c_s, c_e, 0, 2, 0, 1, ST_OVERLAP, 2, 3));
    plan.push_back(plan_row(MODE_DEL, 0, 0, 0, 7'd127, 0, 1, ST_BADSLOT, 0, 3));
    plan.push_back(plan_row(MODE_DEL, 0, 0, 0, 7'd3, 0, 1, ST_BADSLOT, 0, 3));
    plan.push_back(plan_row(MODE_DEL, 0, 0, 0, 7'd0, 0, 0, ST_OK, 0, 0));
    plan.push_back(plan_row(MODE_POP, 0, 0, 0, 0, 0, 0, ST_OK, 0, 0));
    plan.push_back(plan_row(MODE_POP, 0, 0, 0, 0, 0, 0, ST_OK, 0, 0));
    plan.push_back(plan_row(MODE_POP, 0, 0, 0, 0, 0, 1, ST_EMPTY, 0, 0));

    // Hold reset, then release it at a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i])
      offer_item(plan[i].mode, plan[i].s, plan[i].e, plan[i].pri, plan[i].slot,
                 plan[i].skip, plan[i].typed, plan[i].want);
    wait_for_results();

    // Random run: phases that fill the ring, then churn and drain it
    for (int i = 0; i < RAND_ITEMS; i++) begin
      case ((i / 125) % 4)
        0, 1:    drift = GROW;
        2:       drift = SHRINK;
        default: drift = MIXED;
      endcase
      case (drift)
        GROW:    begin pcut = 80; ocut = 85; dcut = 90; qcut = 95; end
        SHRINK:  begin pcut = 15; ocut = 50; dcut = 85; qcut = 95; end
        default: begin pcut = 40; ocut = 60; dcut = 75; qcut = 95; end
      endcase
      calm = (i >= 400 && i < 550);
      if (i == 300) stall_request = 1'b1;
      if (i == 700) wait_for_results();

      a    = $urandom;
      b    = $urandom;
      p    = $urandom_range(255);
      sl   = $urandom_range(127);
      sk   = $urandom_range(1);
      roll = $urandom_range(99);

      if (roll < pcut) begin
        m    = MODE_PUSH;
        roll = $urandom_range(99);
        if (roll < 12 && shadow_count > 0) begin
          // aim at a live entry: copy, touch either bound, or cover its month
          k = live_slot($urandom_range(shadow_count - 1));
          case ($urandom_range(3))
            0: begin a = shadow_start[k]; b = shadow_end[k]; end
            1: begin a = shadow_end[k]; b = {shadow_end[k][31:6], 6'd59}; end
            2: begin a = {shadow_start[k][31:6], 6'd0}; b = shadow_start[k]; end
            default: begin
              a = {shadow_start[k][31:16], 5'd1, 5'd0, 6'd0};
              b = {shadow_end[k][31:16], 5'd31, 5'd23, 6'd59};
            end
          endcase
        end else if (roll >= 17) begin
          fresh_interval(a, b);
        end
      end else if (roll < ocut) begin
        m = MODE_POP;
      end else if (roll < dcut) begin
        m = MODE_DEL;
        if (shadow_count > 0 && $urandom_range(99) < 80)
          sl = live_slot($urandom_range(shadow_count - 1));
      end else if (roll < qcut) begin
        m = MODE_QUERY;
        if (shadow_count > 0 && $urandom_range(1) == 1) begin
          k = live_slot($urandom_range(shadow_count - 1));
          a = shadow_start[k];
          b = shadow_end[k];
          if ($urandom_range(1) == 1) sl = k;
        end
      end else begin
        m = mode_t'($urandom_range(3));
      end
      offer_item(m, a, b, p, sl, sk, 1'b0, none);
    end
    calm = 1'b0;

    // Let the last results drain, then allow for a final scan
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("items: push %0d, pop %0d, delete %0d, query %0d; peak occupancy %0d of %0d",
             mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3], peak_count, DEPTH);
    $display("outcomes: ok %0d, full %0d, overlap %0d, invalid %0d, empty %0d, bad slot %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: interval_ring_queue_with_overlap_check.f
rtl/core/irqoc_pkg.sv
rtl/core/irqoc_mem.sv
rtl/core/irqoc_cmp.sv
rtl/core/irqoc_ctrl.sv
rtl/core/interval_ring_queue_with_overlap_check.sv
sim/testbench.sv
